// ===== rtl/hpts_pkg.sv =====
// ----------------------------------------------------------------------------
// hpts_pkg
// shared codes and types for the handle pool with tag sweep
// ----------------------------------------------------------------------------
package hpts_pkg;

    localparam int CMD_W    = 3;
    localparam int TAG_IN_W = 4;
    localparam int GEN_W    = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC      = 3'd0,
        CMD_RELEASE    = 3'd1,
        CMD_TOUCH      = 3'd2,
        CMD_FREE_TAG   = 3'd3,
        CMD_FREE_STALE = 3'd4,
        CMD_FREE_ALL   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_HEAD,
        S_CHECK,
        S_DROP0,
        S_DROP1,
        S_DROP2,
        S_SW_RD,
        S_SW_EV,
        S_FINISH
    } state_t;

endpackage

// ===== rtl/hpts_entry_ram.sv =====
// ----------------------------------------------------------------------------
// hpts_entry_ram
// per-handle entry store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module hpts_entry_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 54
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/handle_pool_with_tag_sweep.sv =====
// ----------------------------------------------------------------------------
// handle_pool_with_tag_sweep
// fixed pool of handles 1..POOL_SIZE with a lifo free list and an active list
//
// input channel (s_*): one word per command; s_tuser is the command, s_tdata
// carries handle_in and tag_in. output channel (m_*): exactly one result word
// per command with the granted handle, a status code, the number of handles
// freed and the active count after the command.
// current_generation must be written through cfg_we / cfg_wdata only while
// idle; the block itself does not enforce this. commands run one at a time
// through the entry memory, whose single write port sets the pace. the block
// is ready for the next command once its result is in the output register,
// even when that result is still waiting to be taken. reset is immediate: a
// fill count marks handles never handed out, so the memory needs no clearing
// pass. a stalled receiver holds the result in the output register and the
// block waits before loading the next result.
// ----------------------------------------------------------------------------
module handle_pool_with_tag_sweep #(
    parameter int  POOL_SIZE = 1024,
    parameter int  TAG_BITS  = 4,
    localparam int HW        = $clog2(POOL_SIZE + 1),
    localparam int IN_W      = ((HW + hpts_pkg::TAG_IN_W + 7) / 8) * 8,
    localparam int OUT_W     = ((3 * HW + 2 + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command word: handle_in, tag_in (lowest bits first)
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_W-1:0]            s_tdata,
    // command code
    input  logic [hpts_pkg::CMD_W-1:0] s_tuser,
    // result word: handle_out, status, released_count, active_count
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata,
    // current_generation register
    input  logic                       cfg_we,
    input  logic [hpts_pkg::GEN_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(POOL_SIZE);
    // sentinel pointer, also the empty mark of the free list
    localparam logic [HW-1:0] SENT = HW'(POOL_SIZE);

    typedef struct packed {
        logic                       used;
        logic [TAG_BITS-1:0]        tag;
        logic [hpts_pkg::GEN_W-1:0] gen;
        logic [HW-1:0]              prev;   // toward newer entries
        logic [HW-1:0]              next;   // toward older entries
        logic [HW-1:0]              flink;  // free list link
    } entry_t;

    localparam int EW = $bits(entry_t);

    // control state
    hpts_pkg::state_t           state_reg, state_next;
    logic [HW-1:0]              free_top_reg, free_top_next;
    logic [HW-1:0]              fill_reg, fill_next;     // handles ever handed out
    logic [HW-1:0]              head_reg, head_next;     // newest active
    logic [HW-1:0]              tail_reg, tail_next;     // oldest active
    logic [HW-1:0]              live_reg, live_next;
    logic [hpts_pkg::GEN_W-1:0] gen_reg;
    logic                       mvalid_reg, mvalid_next;

    // payload state
    hpts_pkg::cmd_t             cmd_reg, cmd_next;
    hpts_pkg::status_t          status_reg, status_next;
    logic [AW-1:0]              hnd_reg, hnd_next;       // entry under work
    logic [TAG_BITS-1:0]        tag_reg, tag_next;
    logic [HW-1:0]              cur_reg, cur_next;       // sweep position
    logic [HW-1:0]              count_reg, count_next;
    logic [HW-1:0]              hout_reg, hout_next;
    entry_t                     w_reg, w_next;           // entry being dropped
    entry_t                     nword_reg, nword_next;   // neighbor being relinked
    logic [OUT_W-1:0]           mdata_reg, mdata_next;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        wr_entry;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    logic [EW-1:0] ram_rdata_a;
    logic [EW-1:0] ram_rdata_b;
    entry_t        rd_word;
    entry_t        rd_b_word;

    // decoded input word
    logic                s_accept;
    hpts_pkg::cmd_t      in_cmd;
    logic [HW-1:0]       in_handle;
    logic [HW-1:0]       in_hm1;
    logic [AW-1:0]       in_index;
    logic                in_handle_ok;
    logic [TAG_BITS-1:0] in_tag;

    // conditions
    logic          pool_empty;
    logic          virgin;
    logic          head_is_sent;
    logic          entry_active;
    logic          sweep_hit;
    logic          out_free;
    logic [HW-1:0] hnd_ext;

    hpts_entry_ram #(
        .DEPTH (POOL_SIZE),
        .AW    (AW),
        .DW    (EW)
    ) u_entry_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (wr_entry),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    assign rd_word   = entry_t'(ram_rdata_a);
    assign rd_b_word = entry_t'(ram_rdata_b);

    assign s_tready  = (state_reg == hpts_pkg::S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_cmd    = hpts_pkg::cmd_t'(s_tuser);
    assign in_handle = s_tdata[HW-1:0];
    assign in_hm1    = in_handle - HW'(1);
    assign in_index  = in_hm1[AW-1:0];
    assign in_handle_ok = (in_handle != '0) && (in_handle <= SENT);

    // tag bits above TAG_BITS are dropped, missing ones read as zero
    for (genvar b = 0; b < TAG_BITS; b++)
    begin : g_tag
        if (b < hpts_pkg::TAG_IN_W)
        begin : g_bit
            assign in_tag[b] = s_tdata[HW + b];
        end
        else
        begin : g_zero
            assign in_tag[b] = 1'b0;
        end
    end

    assign pool_empty   = (free_top_reg == SENT);
    // the free list reaches the never-used handles only at the fill mark
    assign virgin       = (free_top_reg == fill_reg);
    assign head_is_sent = (head_reg == SENT);
    assign hnd_ext      = HW'(hnd_reg);
    // entries past the fill mark were never written and are not in use
    assign entry_active = (hnd_ext < fill_reg) && rd_word.used;
    assign out_free     = !mvalid_reg || m_tready;

    always_comb
    begin
        case (cmd_reg)
            hpts_pkg::CMD_FREE_TAG:   sweep_hit = (rd_word.tag == tag_reg);
            hpts_pkg::CMD_FREE_STALE: sweep_hit = (rd_word.gen != gen_reg);
            hpts_pkg::CMD_FREE_ALL:   sweep_hit = 1'b1;
            default:                  sweep_hit = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hpts_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_cmd)
                        hpts_pkg::CMD_ALLOC:
                            state_next = pool_empty ? hpts_pkg::S_FINISH : hpts_pkg::S_ALLOC;
                        hpts_pkg::CMD_RELEASE, hpts_pkg::CMD_TOUCH:
                            state_next = in_handle_ok ? hpts_pkg::S_CHECK : hpts_pkg::S_FINISH;
                        hpts_pkg::CMD_FREE_TAG, hpts_pkg::CMD_FREE_STALE,
                        hpts_pkg::CMD_FREE_ALL:
                            state_next = hpts_pkg::S_SW_RD;
                        default:
                            state_next = hpts_pkg::S_FINISH;
                    endcase
                end
            end
            hpts_pkg::S_ALLOC:
                state_next = head_is_sent ? hpts_pkg::S_FINISH : hpts_pkg::S_ALLOC_HEAD;
            hpts_pkg::S_ALLOC_HEAD:
                state_next = hpts_pkg::S_FINISH;
            hpts_pkg::S_CHECK:
            begin
                if (!entry_active || cmd_reg == hpts_pkg::CMD_TOUCH)
                begin
                    state_next = hpts_pkg::S_FINISH;
                end
                else
                begin
                    state_next = hpts_pkg::S_DROP0;
                end
            end
            hpts_pkg::S_DROP0:
                state_next = hpts_pkg::S_DROP1;
            hpts_pkg::S_DROP1:
                state_next = hpts_pkg::S_DROP2;
            hpts_pkg::S_DROP2:
                state_next = (cmd_reg == hpts_pkg::CMD_RELEASE) ? hpts_pkg::S_FINISH
                                                                : hpts_pkg::S_SW_RD;
            hpts_pkg::S_SW_RD:
                state_next = (cur_reg == SENT) ? hpts_pkg::S_FINISH : hpts_pkg::S_SW_EV;
            hpts_pkg::S_SW_EV:
            begin
                if (sweep_hit)
                begin
                    state_next = hpts_pkg::S_DROP0;
                end
                else if (rd_word.prev == SENT)
                begin
                    state_next = hpts_pkg::S_FINISH;
                end
            end
            hpts_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = hpts_pkg::S_IDLE;
                end
            end
            default:
                state_next = hpts_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        free_top_next = free_top_reg;
        fill_next     = fill_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        live_next     = live_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        hnd_next      = hnd_reg;
        tag_next      = tag_reg;
        cur_next      = cur_reg;
        count_next    = count_reg;
        hout_next     = hout_reg;
        w_next        = w_reg;
        nword_next    = nword_reg;
        mdata_next    = mdata_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        ram_we        = 1'b0;
        ram_waddr     = hnd_reg;
        wr_entry      = rd_word;
        ram_raddr_a   = hnd_reg;
        ram_raddr_b   = hnd_reg;

        case (state_reg)
            hpts_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    cmd_next    = in_cmd;
                    tag_next    = in_tag;
                    count_next  = '0;
                    hout_next   = '0;
                    status_next = hpts_pkg::ST_OK;
                    cur_next    = tail_reg;
                    case (in_cmd)
                        hpts_pkg::CMD_ALLOC:
                        begin
                            if (pool_empty)
                            begin
                                status_next = hpts_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr_a = free_top_reg[AW-1:0];
                                ram_raddr_b = head_reg[AW-1:0];
                                hnd_next    = free_top_reg[AW-1:0];
                            end
                        end
                        hpts_pkg::CMD_RELEASE, hpts_pkg::CMD_TOUCH:
                        begin
                            if (in_handle_ok)
                            begin
                                ram_raddr_a = in_index;
                                hnd_next    = in_index;
                            end
                            else
                            begin
                                status_next = hpts_pkg::ST_BAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            hpts_pkg::S_ALLOC:
            begin
                // new entry goes in at the head
                ram_we         = 1'b1;
                ram_waddr      = hnd_reg;
                wr_entry.used  = 1'b1;
                wr_entry.tag   = tag_reg;
                wr_entry.gen   = gen_reg;
                wr_entry.prev  = SENT;
                wr_entry.next  = head_reg;
                wr_entry.flink = '0;
                if (virgin)
                begin
                    free_top_next = fill_reg + HW'(1);
                    fill_next     = fill_reg + HW'(1);
                end
                else
                begin
                    free_top_next = rd_word.flink;
                end
                live_next = live_reg + HW'(1);
                hout_next = hnd_ext + HW'(1);
                if (head_is_sent)
                begin
                    head_next = hnd_ext;
                    tail_next = hnd_ext;
                end
                else
                begin
                    nword_next = rd_b_word;
                end
            end
            hpts_pkg::S_ALLOC_HEAD:
            begin
                ram_we        = 1'b1;
                ram_waddr     = head_reg[AW-1:0];
                wr_entry      = nword_reg;
                wr_entry.prev = hnd_ext;
                head_next     = hnd_ext;
            end
            hpts_pkg::S_CHECK:
            begin
                if (!entry_active)
                begin
                    status_next = hpts_pkg::ST_BAD;
                end
                else if (cmd_reg == hpts_pkg::CMD_TOUCH)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = hnd_reg;
                    wr_entry.gen = gen_reg;
                end
                else
                begin
                    w_next = rd_word;
                end
            end
            hpts_pkg::S_DROP0:
            begin
                // free the entry, fetch both neighbors
                ram_raddr_a    = w_reg.prev[AW-1:0];
                ram_raddr_b    = w_reg.next[AW-1:0];
                ram_we         = 1'b1;
                ram_waddr      = hnd_reg;
                wr_entry       = w_reg;
                wr_entry.used  = 1'b0;
                wr_entry.flink = free_top_reg;
                free_top_next  = hnd_ext;
                live_next      = live_reg - HW'(1);
                count_next     = count_reg + HW'(1);
            end
            hpts_pkg::S_DROP1:
            begin
                nword_next = rd_b_word;
                if (w_reg.prev != SENT)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = w_reg.prev[AW-1:0];
                    wr_entry      = rd_word;
                    wr_entry.next = w_reg.next;
                end
                else
                begin
                    head_next = w_reg.next;
                end
            end
            hpts_pkg::S_DROP2:
            begin
                if (w_reg.next != SENT)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = w_reg.next[AW-1:0];
                    wr_entry      = nword_reg;
                    wr_entry.prev = w_reg.prev;
                end
                else
                begin
                    tail_next = w_reg.prev;
                end
            end
            hpts_pkg::S_SW_RD:
            begin
                ram_raddr_a = cur_reg[AW-1:0];
                hnd_next    = cur_reg[AW-1:0];
            end
            hpts_pkg::S_SW_EV:
            begin
                // walk toward newer entries
                cur_next = rd_word.prev;
                if (sweep_hit)
                begin
                    w_next = rd_word;
                end
                else
                begin
                    ram_raddr_a = rd_word.prev[AW-1:0];
                    hnd_next    = rd_word.prev[AW-1:0];
                end
            end
            hpts_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = OUT_W'({live_reg, count_reg, status_reg, hout_reg});
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hpts_pkg::S_IDLE;
            free_top_reg <= '0;
            fill_reg     <= '0;
            head_reg     <= SENT;
            tail_reg     <= SENT;
            live_reg     <= '0;
            gen_reg      <= '0;
            mvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            free_top_reg <= free_top_next;
            fill_reg     <= fill_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            live_reg     <= live_next;
            mvalid_reg   <= mvalid_next;
            if (cfg_we)
            begin
                gen_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        hnd_reg    <= hnd_next;
        tag_reg    <= tag_next;
        cur_reg    <= cur_next;
        count_reg  <= count_next;
        hout_reg   <= hout_next;
        w_reg      <= w_next;
        nword_reg  <= nword_next;
        mdata_reg  <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ===== rtl/hpts_checker.sv =====
// ----------------------------------------------------------------------------
// hpts_checker
// port-level checks on the result channel of the handle pool
// ----------------------------------------------------------------------------
module hpts_checker #(
    parameter int  POOL_SIZE = 1024,
    localparam int HW        = $clog2(POOL_SIZE + 1),
    localparam int OUT_W     = ((3 * HW + 2 + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [HW-1:0] hout;
    logic [1:0]    status;
    logic [HW-1:0] released;
    logic [HW-1:0] active;

    assign hout     = m_tdata[HW-1:0];
    assign status   = m_tdata[HW+1:HW];
    assign released = m_tdata[2*HW+1:HW+2];
    assign active   = m_tdata[3*HW+1:2*HW+2];

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result word valid out of reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && hout != '0 |->
            status == hpts_pkg::ST_OK && released == '0 && active != '0)
        else $error("granted handle with bad status or counts");

    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status != hpts_pkg::ST_OK |->
            hout == '0 && released == '0 &&
            (status == hpts_pkg::ST_EMPTY || status == hpts_pkg::ST_BAD))
        else $error("failed command reports a handle or a release");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> active <= HW'(POOL_SIZE) && released <= HW'(POOL_SIZE))
        else $error("count beyond pool size");

endmodule

bind handle_pool_with_tag_sweep hpts_checker #(
    .POOL_SIZE (POOL_SIZE)
) u_hpts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
